/* rtl/core/vtce_pkg.sv */
// ----------------------------------------------------------------------------
// vtce_pkg
// Shared constants, types and helpers of the vector terminal coordinate
// encoder.
// ----------------------------------------------------------------------------
package vtce_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned ActW   = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned PartW  = 5;
  localparam int unsigned ExW    = 4;
  localparam int unsigned PadW   = 3;
  localparam int unsigned DistW  = PartW + 2;

  localparam logic [ActW-1:0] ActMove       = 3'd0;
  localparam logic [ActW-1:0] ActDraw       = 3'd1;
  localparam logic [ActW-1:0] ActPoint      = 3'd2;
  localparam logic [ActW-1:0] ActErase      = 3'd3;
  localparam logic [ActW-1:0] ActStyle      = 3'd4;
  localparam logic [ActW-1:0] ActAlphaStart = 3'd5;
  localparam logic [ActW-1:0] ActAlphaChar  = 3'd6;

  localparam logic [ByteW-1:0] ChGs        = 8'h1D;
  localparam logic [ByteW-1:0] ChEsc       = 8'h1B;
  localparam logic [ByteW-1:0] ChFf        = 8'h0C;
  localparam logic [ByteW-1:0] ChUs        = 8'h1F;
  localparam logic [ByteW-1:0] ChStyleBase = 8'h60;
  localparam logic [ByteW-1:0] ChNull      = 8'h00;
  localparam logic [ByteW-1:0] StyleMax    = 8'd4;

  localparam logic [2:0] PfxHigh  = 3'b001;
  localparam logic [2:0] PfxLowX  = 3'b010;
  localparam logic [2:0] PfxLowY  = 3'b011;
  localparam logic [3:0] PfxExtra = 4'b0110;

  localparam int unsigned PadStep = 12;
  localparam int unsigned PadBias = 6;
  localparam int unsigned PadMax  = 5;

  localparam int unsigned SlotLead0 = 0;
  localparam int unsigned SlotLead1 = 1;
  localparam int unsigned SlotHy    = 2;
  localparam int unsigned SlotEx    = 3;
  localparam int unsigned SlotLy    = 4;
  localparam int unsigned SlotHx    = 5;
  localparam int unsigned SlotLx    = 6;
  localparam int unsigned SlotPad   = 7;
  localparam int unsigned SlotLx2   = 8;
  localparam int unsigned NumSlots  = 9;
  localparam int unsigned SlotIdxW  = 4;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QCntW  = 2;

  typedef struct packed {
    logic [NumSlots-1:0] mask;
    logic [ByteW-1:0]    lead0;
    logic [ByteW-1:0]    lead1;
    logic [PartW-1:0]    hy;
    logic [ExW-1:0]      ex;
    logic [PartW-1:0]    ly;
    logic [PartW-1:0]    hx;
    logic [PartW-1:0]    lx;
    logic [PadW-1:0]     pad;
  } desc_t;

  function automatic logic [PadW-1:0] pad_count(input logic [DistW-1:0] span);
    logic [PadW-1:0] p;
    p = '0;
    for (int k = 0; k < PadMax; k++) begin
      if (span >= DistW'(PadBias + PadStep * k)) begin
        p = PadW'(k + 1);
      end
    end
    return p;
  endfunction

endpackage

/* rtl/core/vtce_if.sv */
// ----------------------------------------------------------------------------
// vtce channel interfaces
// Command channel into the encoder and byte channel out of it.
// ----------------------------------------------------------------------------
interface vtce_cmd_if;
  import vtce_pkg::*;
  logic              valid;
  logic              ready;
  logic [ActW-1:0]   action;
  logic [CoordW-1:0] coord_x;
  logic [CoordW-1:0] coord_y;
  logic [ByteW-1:0]  payload;

  modport source (output valid, action, coord_x, coord_y, payload, input ready);
  modport sink   (input valid, action, coord_x, coord_y, payload, output ready);
endinterface

interface vtce_byte_if;
  import vtce_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             last_byte;

  modport source (output valid, out_byte, last_byte, input ready);
  modport sink   (input valid, out_byte, last_byte, output ready);
endinterface

/* rtl/core/vtce_queue.sv */
// ----------------------------------------------------------------------------
// vtce_queue
// Two-entry descriptor queue between the command front end and the byte
// sequencer.
// ----------------------------------------------------------------------------
module vtce_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  vtce_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output vtce_pkg::desc_t head_o
);
  import vtce_pkg::*;

  desc_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");

endmodule

/* rtl/core/vtce_front.sv */
// ----------------------------------------------------------------------------
// vtce_front
// Command front end: classify each command, compare the coordinate parts
// with the last ones sent, work out the padding and queue a byte plan.
// ----------------------------------------------------------------------------
module vtce_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  vtce_cmd_if.sink        cmd_i,
  input  logic            q_full_i,
  output logic            push_o,
  output vtce_pkg::desc_t desc_o
);
  import vtce_pkg::*;

  logic [PartW-1:0] phy_q, phx_q, ply_q;
  logic [ExW-1:0]   pex_q;
  logic             hy_kn_q, hx_kn_q, ly_kn_q, ex_kn_q;
  logic             known_d, clear_pos, set_pos;

  logic [PartW-1:0] hx, hy, lx, ly;
  logic [ExW-1:0]   ex;
  logic             hy_diff, hx_diff, ly_diff, ex_diff;
  logic [PartW:0]   dhx, dhy;
  logic [DistW-1:0] span;
  logic [PadW-1:0]  pad;
  logic             accept, is_coord;
  logic [ByteW-1:0] style_ch;

  assign hx = cmd_i.coord_x[CoordW-1 -: PartW];
  assign lx = cmd_i.coord_x[PartW+1:2];
  assign hy = cmd_i.coord_y[CoordW-1 -: PartW];
  assign ly = cmd_i.coord_y[PartW+1:2];
  assign ex = {cmd_i.coord_y[1:0], cmd_i.coord_x[1:0]};

  assign hy_diff = !hy_kn_q || (hy != phy_q);
  assign hx_diff = !hx_kn_q || (hx != phx_q);
  assign ly_diff = !ly_kn_q || (ly != ply_q);
  assign ex_diff = !ex_kn_q || (ex != pex_q);

  always_comb begin
    if (!hx_kn_q) begin
      dhx = {1'b0, hx} + 1'b1;
    end else if (hx >= phx_q) begin
      dhx = {1'b0, hx - phx_q};
    end else begin
      dhx = {1'b0, phx_q - hx};
    end
    if (!hy_kn_q) begin
      dhy = {1'b0, hy} + 1'b1;
    end else if (hy >= phy_q) begin
      dhy = {1'b0, hy - phy_q};
    end else begin
      dhy = {1'b0, phy_q - hy};
    end
    span = {1'b0, dhx} + {1'b0, dhy};
    pad  = pad_count(span);
  end

  assign style_ch = (cmd_i.payload <= StyleMax) ? ChStyleBase + cmd_i.payload : ChStyleBase;
  assign is_coord = (cmd_i.action == ActMove) || (cmd_i.action == ActDraw) ||
                    (cmd_i.action == ActPoint);

  assign cmd_i.ready = !q_full_i;
  assign accept      = cmd_i.valid && cmd_i.ready;

  always_comb begin
    desc_o       = '0;
    desc_o.hy    = hy;
    desc_o.ex    = ex;
    desc_o.ly    = ly;
    desc_o.hx    = hx;
    desc_o.lx    = lx;
    desc_o.pad   = pad;
    desc_o.lead0 = ChGs;
    desc_o.lead1 = ChFf;
    if (is_coord) begin
      desc_o.mask[SlotHy]  = hy_diff;
      desc_o.mask[SlotEx]  = ex_diff;
      desc_o.mask[SlotLy]  = hx_diff || ex_diff || ly_diff;
      desc_o.mask[SlotHx]  = hx_diff;
      desc_o.mask[SlotLx]  = 1'b1;
      desc_o.mask[SlotPad] = (pad != '0);
    end
    unique case (cmd_i.action)
      ActMove: begin
        desc_o.mask[SlotLead0] = 1'b1;
      end
      ActDraw: begin
      end
      ActPoint: begin
        desc_o.mask[SlotLead0] = 1'b1;
        desc_o.mask[SlotLx2]   = 1'b1;
      end
      ActErase: begin
        desc_o.lead0                      = ChEsc;
        desc_o.mask[SlotLead1:SlotLead0]  = 2'b11;
      end
      ActStyle: begin
        desc_o.lead0                      = ChEsc;
        desc_o.lead1                      = style_ch;
        desc_o.mask[SlotLead1:SlotLead0]  = 2'b11;
      end
      ActAlphaStart: begin
        desc_o.lead0           = ChUs;
        desc_o.mask[SlotLead0] = 1'b1;
      end
      ActAlphaChar: begin
        desc_o.lead0           = cmd_i.payload;
        desc_o.mask[SlotLead0] = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // drop commands that produce no bytes
  assign push_o    = accept && (desc_o.mask != '0);
  assign set_pos   = accept && is_coord;
  assign clear_pos = accept && ((cmd_i.action == ActErase) ||
                                (cmd_i.action == ActAlphaStart));
  assign known_d   = set_pos;

  always_ff @(posedge clk_i) begin
    if (set_pos) begin
      phy_q <= hy;
      phx_q <= hx;
      ply_q <= ly;
      pex_q <= ex;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hy_kn_q <= 1'b0;
      hx_kn_q <= 1'b0;
      ly_kn_q <= 1'b0;
      ex_kn_q <= 1'b0;
    end else if (set_pos || clear_pos) begin
      hy_kn_q <= known_d;
      hx_kn_q <= known_d;
      ly_kn_q <= known_d;
      ex_kn_q <= known_d;
    end
  end

endmodule

/* rtl/core/vtce_back.sv */
// ----------------------------------------------------------------------------
// vtce_back
// Byte sequencer: walk the planned slots of one command, one byte per
// transfer, and hold each byte in the output register.
// ----------------------------------------------------------------------------
module vtce_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  vtce_pkg::desc_t head_i,
  input  logic            q_empty_i,
  output logic            pop_o,
  vtce_byte_if.source     byte_o
);
  import vtce_pkg::*;

  function automatic logic [SlotIdxW-1:0] first_slot(input logic [NumSlots-1:0] m);
    logic [SlotIdxW-1:0] idx;
    idx = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (m[i]) begin
        idx = SlotIdxW'(i);
      end
    end
    return idx;
  endfunction

  desc_t               cur_q;
  logic                cur_vld_q, cur_vld_d;
  logic [NumSlots-1:0] mask_q, mask_d, mask_nxt;
  logic [PadW-1:0]     pad_q, pad_d, pad_nxt;
  logic                out_vld_q;
  logic [ByteW-1:0]    out_byte_q, sel_byte;
  logic                out_last_q;

  logic                out_free, step, last, done;
  logic [SlotIdxW-1:0] slot;

  assign out_free = !out_vld_q || byte_o.ready;
  assign step     = cur_vld_q && out_free;
  assign slot     = first_slot(mask_q);

  always_comb begin
    mask_nxt = mask_q & ~(NumSlots'(1) << slot);
    pad_nxt  = pad_q;
    sel_byte = ChNull;
    case (slot)
      SlotIdxW'(SlotLead0): sel_byte = cur_q.lead0;
      SlotIdxW'(SlotLead1): sel_byte = cur_q.lead1;
      SlotIdxW'(SlotHy):    sel_byte = {PfxHigh, cur_q.hy};
      SlotIdxW'(SlotEx):    sel_byte = {PfxExtra, cur_q.ex};
      SlotIdxW'(SlotLy):    sel_byte = {PfxLowY, cur_q.ly};
      SlotIdxW'(SlotHx):    sel_byte = {PfxHigh, cur_q.hx};
      SlotIdxW'(SlotLx):    sel_byte = {PfxLowX, cur_q.lx};
      SlotIdxW'(SlotLx2):   sel_byte = {PfxLowX, cur_q.lx};
      SlotIdxW'(SlotPad): begin
        sel_byte = ChNull;
        pad_nxt  = pad_q - 1'b1;
        if (pad_q != PadW'(1)) begin
          mask_nxt = mask_q;
        end
      end
      default: sel_byte = ChNull;
    endcase
  end

  assign last  = (mask_nxt == '0);
  assign done  = !cur_vld_q || (step && last);
  assign pop_o = done && !q_empty_i;

  always_comb begin
    cur_vld_d = cur_vld_q;
    mask_d    = mask_q;
    pad_d     = pad_q;
    if (step) begin
      mask_d = mask_nxt;
      pad_d  = pad_nxt;
    end
    if (done) begin
      cur_vld_d = pop_o;
    end
    if (pop_o) begin
      mask_d = head_i.mask;
      pad_d  = head_i.pad;
    end
  end

  assign byte_o.valid     = out_vld_q;
  assign byte_o.out_byte  = out_byte_q;
  assign byte_o.last_byte = out_last_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
    mask_q <= mask_d;
    pad_q  <= pad_d;
    if (step) begin
      out_byte_q <= sel_byte;
      out_last_q <= last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      if (step) begin
        out_vld_q <= 1'b1;
      end else if (byte_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  a_cur_has_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> (mask_q != '0))
    else $error("active command with no bytes left");

  a_pad_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cur_vld_q && mask_q[SlotPad]) |-> (pad_q != '0))
    else $error("padding slot with zero count");

  a_pop_ends_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && cur_vld_q) |=> (out_vld_q && out_last_q))
    else $error("new command loaded before last byte of previous one");

endmodule

/* rtl/core/vector_terminal_coord_encoder.sv */
// ----------------------------------------------------------------------------
// vector_terminal_coord_encoder
// Drawing commands in, vector terminal byte stream out.
// ----------------------------------------------------------------------------
// Each command becomes one to twelve bytes on byte_o, with last_byte set on
// the final byte of the command; an undefined action is taken and yields
// nothing. The byte sequencer puts out one byte per cycle while the output
// is not stalled by byte_o.ready; a command has 1 byte for a character and
// up to 12 for a point after a long jump. The front end takes one command
// per cycle while its two-entry plan queue has room, so commands keep
// flowing while earlier bytes are still waiting on the output.
module vector_terminal_coord_encoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  vtce_cmd_if.sink     cmd_i,
  vtce_byte_if.source  byte_o
);
  import vtce_pkg::*;

  desc_t push_desc, head_desc;
  logic  push, pop, q_full, q_empty;

  vtce_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd_i),
    .q_full_i (q_full),
    .push_o   (push),
    .desc_o   (push_desc)
  );

  vtce_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (push_desc),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (head_desc)
  );

  vtce_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head_desc),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .byte_o    (byte_o)
  );

endmodule
